/* sv/fpsa_pkg.sv */
// Shared constants, types and codes for the segment allocator.
package fpsa_pkg;

  localparam int FREE_SLOTS   = 16;
  localparam int LIVE_SLOTS   = 16;
  localparam int ADDR_BITS    = 20;
  localparam int HEADER_BYTES = 8;

  localparam int FIDX_W = $clog2(FREE_SLOTS);
  localparam int FCNT_W = $clog2(FREE_SLOTS + 1);
  localparam int LIDX_W = $clog2(LIVE_SLOTS);
  localparam int LCNT_W = $clog2(LIVE_SLOTS + 1);
  localparam int SCAN_W = (FCNT_W > LCNT_W) ? FCNT_W : LCNT_W;

  localparam int LEN_W    = 21;
  localparam int SIZE_W   = 21;
  localparam int NEED_W   = 22;
  localparam int FADDR_W  = 20;
  localparam int CFG_W    = 21;
  localparam int CIDX_W   = 1;

  // Region size limits
  localparam longint SPACE_BYTES = 64'd1 << ADDR_BITS;
  localparam longint TOP_BYTES   = (SPACE_BYTES < 64'd1048576) ? SPACE_BYTES : 64'd1048576;
  localparam logic [LEN_W-1:0] REGION_MIN   = LEN_W'(4096);
  localparam logic [LEN_W-1:0] REGION_TOP   = LEN_W'(TOP_BYTES);
  localparam logic [LEN_W-1:0] REGION_RESET = LEN_W'(65536);

  // Request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Placement policies (code 3 behaves as first fit)
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_REGION = 1'b0;
  localparam logic [CIDX_W-1:0] REG_POLICY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // One table entry: segment or live block
  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0]     len;
  } seg_t;

endpackage

/* sv/fpsa_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module fpsa_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 41
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/fit_policy_segment_allocator_top.sv */
// Segment allocator top level: sequencer over the free and live tables.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------
//  in      | in_valid  | in_stall  | action, req_size, free_addr
//  out     | out_valid | out_stall | block_addr, status
//  cfg     | cfg_we    | -         | cfg_index, cfg_data
//
// One request at a time. Allocate scans the free table, writes the live
// entry and the shortened segment, and shifts the free table down when a
// segment is used up. Free scans the live table, then searches the free
// table for the block's position; it merges the block with an adjacent
// segment, or shifts the table up to insert it, and a merge with both sides
// shifts the table down. The free-table RAM has a single read port.
// After reset the S_INIT state writes the initial segment; in_stall is high then.
// A waiting result in the output register does not block the next request.
module fit_policy_segment_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [fpsa_pkg::SIZE_W-1:0]   req_size,
  input  logic [fpsa_pkg::FADDR_W-1:0]  free_addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fpsa_pkg::FADDR_W-1:0]  block_addr,
  output logic [1:0]                    status,
  input  logic                          cfg_we,
  input  logic [fpsa_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [fpsa_pkg::CFG_W-1:0]    cfg_data
);
  import fpsa_pkg::*;

  typedef enum logic [9:0] {
    S_INIT  = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_ASCAN = 10'b00_0000_0100,
    S_AUPD  = 10'b00_0000_1000,
    S_SHDN  = 10'b00_0001_0000,
    S_LSCAN = 10'b00_0010_0000,
    S_FSCAN = 10'b00_0100_0000,
    S_FUPD  = 10'b00_1000_0000,
    S_SHUP  = 10'b01_0000_0000,
    S_RESP  = 10'b10_0000_0000
  } state_t;

  state_t state;

  // Configuration and table bookkeeping
  logic [LEN_W-1:0]      region;
  logic [1:0]            policy;
  logic [FCNT_W-1:0]     seg_count;
  logic [LIVE_SLOTS-1:0] live_valid;

  // Request context
  logic [NEED_W-1:0]     need;
  logic [FADDR_W-1:0]    faddr;
  logic [SCAN_W-1:0]     cnt;
  logic                  rv;
  logic [SCAN_W-1:0]     rix;
  logic                  found;
  logic [FIDX_W-1:0]     pick;
  seg_t                  pk;
  logic                  hit;
  logic [LIDX_W-1:0]     slot;
  logic [ADDR_BITS-1:0]  bstart;
  logic [LEN_W-1:0]      blen;
  seg_t                  prev;
  seg_t                  cur;
  logic [FCNT_W-1:0]     pos;
  logic                  nxt;
  logic                  stop;
  logic [FADDR_W-1:0]    res_addr;
  status_t               res_st;

  // RAM ports
  logic                  seg_we;
  logic [FIDX_W-1:0]     seg_waddr;
  seg_t                  seg_wdata;
  logic [FIDX_W-1:0]     seg_raddr;
  seg_t                  seg_q;
  logic                  live_we;
  logic [LIDX_W-1:0]     live_waddr;
  seg_t                  live_wdata;
  seg_t                  live_q;

  // Derived control
  logic [SCAN_W-1:0]     cnt_dn;
  logic [SCAN_W-1:0]     rix_up;
  logic [SCAN_W-1:0]     rix_dn;
  logic [SCAN_W-1:0]     count_ext;
  logic [SCAN_W-1:0]     pos_ext;
  logic                  rd_issue;
  logic [LEN_W-1:0]      cfg_clamp;
  logic                  have_slot;
  logic [LIDX_W-1:0]     fslot;
  logic                  fits;
  logic                  upd;
  logic                  lmatch;
  logic [NEED_W-1:0]     prev_end;
  logic [NEED_W-1:0]     blk_end;
  logic                  jp;
  logic                  jn;
  logic                  out_load;
  logic                  scan_end;

  fpsa_ram #(.DEPTH(FREE_SLOTS), .WIDTH($bits(seg_t))) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata (seg_wdata),
    .raddr (seg_raddr),
    .rdata (seg_q)
  );

  fpsa_ram #(.DEPTH(LIVE_SLOTS), .WIDTH($bits(seg_t))) u_live_ram (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_waddr),
    .wdata (live_wdata),
    .raddr (cnt[LIDX_W-1:0]),
    .rdata (live_q)
  );

  assign in_stall  = (state != S_IDLE);
  assign cnt_dn    = cnt - SCAN_W'(1);
  assign rix_up    = rix + SCAN_W'(1);
  assign rix_dn    = rix - SCAN_W'(1);
  assign count_ext = SCAN_W'(seg_count);
  assign pos_ext   = SCAN_W'(pos);
  assign out_load  = (state == S_RESP) && (!out_valid || !out_stall);

  // Region clamp on a configuration write
  always_comb begin
    cfg_clamp = cfg_data[LEN_W-1:0];
    if (cfg_clamp < REGION_MIN) begin
      cfg_clamp = REGION_MIN;
    end else if (cfg_clamp > REGION_TOP) begin
      cfg_clamp = REGION_TOP;
    end
  end

  // Lowest free live slot
  always_comb begin
    fslot = '0;
    for (int k = LIVE_SLOTS - 1; k >= 0; k--) begin
      if (!live_valid[k]) begin
        fslot = LIDX_W'(k);
      end
    end
  end
  assign have_slot = ~&live_valid;

  // Scan compares
  assign fits   = ({1'b0, seg_q.len} >= need);
  assign upd    = fits && (!found ||
                  (policy == POL_BEST  && seg_q.len < pk.len) ||
                  (policy == POL_WORST && seg_q.len > pk.len));
  assign lmatch = live_valid[rix[LIDX_W-1:0]] && !hit &&
                  ((NEED_W'(live_q.start) + NEED_W'(HEADER_BYTES)) == NEED_W'(faddr));

  // Merge tests against the neighbours
  assign prev_end = NEED_W'(prev.start) + NEED_W'(prev.len);
  assign blk_end  = NEED_W'(bstart) + NEED_W'(blen);
  assign jp       = (pos != '0) && (prev_end == NEED_W'(bstart));
  assign jn       = nxt && (blk_end == NEED_W'(cur.start));

  // Read issue and scan termination
  always_comb begin
    rd_issue  = 1'b0;
    seg_raddr = cnt[FIDX_W-1:0];
    scan_end  = 1'b0;
    unique case (state)
      S_ASCAN, S_SHDN: begin
        rd_issue = (cnt < count_ext);
        scan_end = !rd_issue && !rv;
      end
      S_FSCAN: begin
        rd_issue = (cnt < count_ext) && !stop;
        scan_end = stop || ((cnt >= count_ext) && !rv);
      end
      S_LSCAN: begin
        rd_issue = (cnt < SCAN_W'(LIVE_SLOTS));
        scan_end = !rd_issue && !rv;
      end
      S_SHUP: begin
        rd_issue  = (cnt > pos_ext);
        seg_raddr = cnt_dn[FIDX_W-1:0];
        scan_end  = !rd_issue && !rv;
      end
      default: begin
      end
    endcase
  end

  // Free-table write port
  always_comb begin
    seg_we    = 1'b0;
    seg_waddr = '0;
    seg_wdata = '0;
    priority case (1'b1)
      (state == S_IDLE) && cfg_we && (cfg_index == REG_REGION): begin
        seg_we        = 1'b1;
        seg_wdata.len = cfg_clamp;
      end
      state == S_INIT: begin
        seg_we        = 1'b1;
        seg_wdata.len = region;
      end
      state == S_AUPD: begin
        seg_we          = 1'b1;
        seg_waddr       = pick;
        seg_wdata.start = pk.start + ADDR_BITS'(need);
        seg_wdata.len   = pk.len - LEN_W'(need);
      end
      (state == S_SHDN) && rv: begin
        seg_we    = 1'b1;
        seg_waddr = rix_dn[FIDX_W-1:0];
        seg_wdata = seg_q;
      end
      (state == S_FUPD) && jp: begin
        seg_we          = 1'b1;
        seg_waddr       = FIDX_W'(pos - FCNT_W'(1));
        seg_wdata.start = prev.start;
        seg_wdata.len   = prev.len + blen + (jn ? cur.len : LEN_W'(0));
      end
      (state == S_FUPD) && jn: begin
        seg_we          = 1'b1;
        seg_waddr       = pos[FIDX_W-1:0];
        seg_wdata.start = bstart;
        seg_wdata.len   = cur.len + blen;
      end
      (state == S_SHUP) && rv: begin
        seg_we    = 1'b1;
        seg_waddr = rix_up[FIDX_W-1:0];
        seg_wdata = seg_q;
      end
      (state == S_SHUP) && scan_end: begin
        seg_we          = 1'b1;
        seg_waddr       = pos[FIDX_W-1:0];
        seg_wdata.start = bstart;
        seg_wdata.len   = blen;
      end
      default: begin
      end
    endcase
  end

  // Live-table write port: new block on a successful allocate
  assign live_we          = (state == S_AUPD);
  assign live_waddr       = fslot;
  assign live_wdata.start = pk.start;
  assign live_wdata.len   = LEN_W'(need);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      region     <= REGION_RESET;
      policy     <= POL_FIRST;
      seg_count  <= FCNT_W'(1);
      live_valid <= '0;
      rv         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rv <= rd_issue;
      if (rd_issue) begin
        rix <= (state == S_SHUP) ? cnt_dn : cnt;
        cnt <= (state == S_SHUP) ? cnt_dn : cnt + SCAN_W'(1);
      end

      if (out_load) begin
        out_valid  <= 1'b1;
        block_addr <= res_addr;
        status     <= res_st;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_we) begin
            unique case (cfg_index)
              REG_REGION: begin
                region     <= cfg_clamp;
                seg_count  <= FCNT_W'(1);
                live_valid <= '0;
              end
              REG_POLICY: policy <= cfg_data[1:0];
            endcase
          end
          if (in_valid) begin
            need     <= ((NEED_W'(req_size) + NEED_W'(3)) & ~NEED_W'(3)) +
                        NEED_W'(HEADER_BYTES);
            faddr    <= free_addr;
            res_addr <= '0;
            cnt      <= '0;
            found    <= 1'b0;
            hit      <= 1'b0;
            if (action == ACT_FREE) begin
              state <= S_LSCAN;
            end else if (req_size == '0) begin
              res_st <= ST_NOFIT;
              state  <= S_RESP;
            end else begin
              state <= S_ASCAN;
            end
          end
        end
        S_ASCAN: begin
          if (rv && upd) begin
            found <= 1'b1;
            pick  <= rix[FIDX_W-1:0];
            pk    <= seg_q;
          end
          if (scan_end) begin
            if (!found) begin
              res_st <= ST_NOFIT;
              state  <= S_RESP;
            end else if (!have_slot) begin
              res_st <= ST_FULL;
              state  <= S_RESP;
            end else begin
              state <= S_AUPD;
            end
          end
        end
        S_AUPD: begin
          live_valid[fslot] <= 1'b1;
          res_addr <= FADDR_W'(pk.start + ADDR_BITS'(HEADER_BYTES));
          res_st   <= ST_OK;
          if ({1'b0, pk.len} == need) begin
            cnt   <= SCAN_W'(pick) + SCAN_W'(1);
            state <= S_SHDN;
          end else begin
            state <= S_RESP;
          end
        end
        S_SHDN: begin
          if (scan_end) begin
            seg_count <= seg_count - FCNT_W'(1);
            state     <= S_RESP;
          end
        end
        S_LSCAN: begin
          if (rv && lmatch) begin
            hit    <= 1'b1;
            slot   <= rix[LIDX_W-1:0];
            bstart <= live_q.start;
            blen   <= live_q.len;
          end
          if (scan_end) begin
            if (!hit) begin
              res_st <= ST_BADFREE;
              state  <= S_RESP;
            end else begin
              cnt   <= '0;
              pos   <= '0;
              nxt   <= 1'b0;
              stop  <= 1'b0;
              state <= S_FSCAN;
            end
          end
        end
        S_FSCAN: begin
          if (rv && !stop) begin
            if (seg_q.start < bstart) begin
              prev <= seg_q;
              pos  <= FCNT_W'(rix_up);
            end else begin
              cur  <= seg_q;
              pos  <= FCNT_W'(rix);
              nxt  <= 1'b1;
              stop <= 1'b1;
            end
          end
          if (scan_end) begin
            state <= S_FUPD;
          end
        end
        S_FUPD: begin
          res_st <= ST_OK;
          if (jp && jn) begin
            live_valid[slot] <= 1'b0;
            cnt   <= pos_ext + SCAN_W'(1);
            state <= S_SHDN;
          end else if (jp || jn) begin
            live_valid[slot] <= 1'b0;
            state <= S_RESP;
          end else if (seg_count >= FCNT_W'(FREE_SLOTS)) begin
            res_st <= ST_FULL;
            state  <= S_RESP;
          end else begin
            cnt   <= count_ext;
            state <= S_SHUP;
          end
        end
        S_SHUP: begin
          if (scan_end) begin
            live_valid[slot] <= 1'b0;
            seg_count <= seg_count + FCNT_W'(1);
            state     <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

endmodule

/* sv/fpsa_checker.sv */
// Port-level checker for the segment allocator, with its bind.
module fpsa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [fpsa_pkg::FADDR_W-1:0]  block_addr,
  input logic [1:0]                    status
);
  import fpsa_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(block_addr) && $stable(status))
    else $error("stalled result changed");

  // Only a successful allocate carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> block_addr == '0)
    else $error("address on a failed request");

  // Payload addresses sit on four-byte boundaries
  a_addr_align: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> block_addr[1:0] == 2'b00)
    else $error("misaligned payload address");

  // One request in flight: busy right after taking one
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // Nothing comes out straight after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result right after reset");

endmodule

bind fit_policy_segment_allocator_top fpsa_checker u_fpsa_checker (.*);

/* tb/tb.sv */
// Testbench for the fit-policy segment allocator: random and directed requests, self-checking.
`timescale 1ns / 1ps

module tb;
  import fpsa_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic                act;
    logic [SIZE_W-1:0]   sz;
    logic [FADDR_W-1:0]  fa;
    bit                  pick_live;
  } req_t;

  typedef struct {
    logic [FADDR_W-1:0] addr;
    status_t            st;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_ALLOC;
  logic [SIZE_W-1:0] req_size = '0;
  logic [FADDR_W-1:0] free_addr = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FADDR_W-1:0] block_addr;
  logic [1:0] status;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = REG_REGION;
  logic [CFG_W-1:0] cfg_data = '0;

  req_t  pending_reqs[$];
  resp_t awaited_resps[$];
  int    cycle_no = 0;
  int    errors = 0;
  int    n_sent = 0;
  int    n_checked = 0;
  int    n_ok = 0, n_nofit = 0, n_bad = 0, n_full = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;

  // Allocator state mirror
  longint fs_start[FREE_SLOTS];
  longint fs_len[FREE_SLOTS];
  int     fs_count;
  longint blk_start[LIVE_SLOTS];
  longint blk_len[LIVE_SLOTS];
  bit     blk_live[LIVE_SLOTS];
  longint region_sz;
  logic [1:0] policy;

  fit_policy_segment_allocator_top dut (.*);

  always #6 clk = ~clk;

  function automatic void clear_tables();
    for (int i = 0; i < FREE_SLOTS; i++) begin
      fs_start[i] = 0;
      fs_len[i] = 0;
    end
    for (int i = 0; i < LIVE_SLOTS; i++) begin
      blk_start[i] = 0;
      blk_len[i] = 0;
      blk_live[i] = 1'b0;
    end
    fs_len[0] = region_sz;
    fs_count = 1;
  endfunction

  function automatic void drop_seg(int idx);
    for (int k = idx; k + 1 < fs_count; k++) begin
      fs_start[k] = fs_start[k+1];
      fs_len[k] = fs_len[k+1];
    end
    fs_count--;
    fs_start[fs_count] = 0;
    fs_len[fs_count] = 0;
  endfunction

  // Expected outcome of one request; updates the mirror
  function automatic resp_t alloc_outcome(req_t r);
    resp_t  res;
    longint need;
    int     pick, slot;
    bit     found, have_slot, jp, jn;
    int     pos;
    longint bs, bl;
    res.addr = '0;
    res.st = ST_OK;
    pick = 0;
    slot = 0;
    found = 1'b0;
    have_slot = 1'b0;
    if (r.act == ACT_ALLOC) begin
      if (r.sz == 0) begin
        res.st = ST_NOFIT;
        return res;
      end
      need = ((longint'(r.sz) + 3) & ~64'd3) + HEADER_BYTES;
      for (int i = 0; i < fs_count; i++) begin
        if (fs_len[i] < need) continue;
        if (!found) begin
          pick = i;
          found = 1'b1;
          if (policy != POL_BEST && policy != POL_WORST) break;
        end else if (policy == POL_BEST && fs_len[i] < fs_len[pick]) begin
          pick = i;
        end else if (policy == POL_WORST && fs_len[i] > fs_len[pick]) begin
          pick = i;
        end
      end
      if (!found) begin
        res.st = ST_NOFIT;
        return res;
      end
      for (int i = 0; i < LIVE_SLOTS; i++) begin
        if (!blk_live[i]) begin
          slot = i;
          have_slot = 1'b1;
          break;
        end
      end
      if (!have_slot) begin
        res.st = ST_FULL;
        return res;
      end
      blk_live[slot] = 1'b1;
      blk_start[slot] = fs_start[pick];
      blk_len[slot] = need;
      res.addr = FADDR_W'(fs_start[pick] + HEADER_BYTES);
      fs_start[pick] += need;
      fs_len[pick] -= need;
      if (fs_len[pick] == 0) drop_seg(pick);
      return res;
    end
    // free request
    for (int i = 0; i < LIVE_SLOTS; i++) begin
      if (blk_live[i] && blk_start[i] + HEADER_BYTES == longint'(r.fa)) begin
        slot = i;
        found = 1'b1;
        break;
      end
    end
    if (!found) begin
      res.st = ST_BADFREE;
      return res;
    end
    bs = blk_start[slot];
    bl = blk_len[slot];
    pos = 0;
    while (pos < fs_count && fs_start[pos] < bs) pos++;
    jp = pos > 0 && fs_start[pos-1] + fs_len[pos-1] == bs;
    jn = pos < fs_count && bs + bl == fs_start[pos];
    if (jp && jn) begin
      fs_len[pos-1] += bl + fs_len[pos];
      drop_seg(pos);
    end else if (jp) begin
      fs_len[pos-1] += bl;
    end else if (jn) begin
      fs_start[pos] = bs;
      fs_len[pos] += bl;
    end else begin
      if (fs_count >= FREE_SLOTS) begin
        res.st = ST_FULL;
        return res;
      end
      for (int k = fs_count; k > pos; k--) begin
        fs_start[k] = fs_start[k-1];
        fs_len[k] = fs_len[k-1];
      end
      fs_start[pos] = bs;
      fs_len[pos] = bl;
      fs_count++;
    end
    blk_live[slot] = 1'b0;
    return res;
  endfunction

  // Quiet window: neither side idles
  function automatic bit quiet();
    return cycle_no >= 3000 && cycle_no < 6000;
  endfunction

  // Request driver
  always @(posedge clk) begin
    req_t  r;
    resp_t e;
    int    live_idx[$];
    cycle_no <= cycle_no + 1;
    if (!rst && (!in_valid || !in_stall)) begin
      if (in_valid) begin
        r.act = action;
        r.sz = req_size;
        r.fa = free_addr;
        r.pick_live = 1'b0;
        e = alloc_outcome(r);
        awaited_resps.push_back(e);
        n_sent++;
      end
      if (pending_reqs.size() > 0 && (quiet() || $urandom_range(99) >= 28)) begin
        r = pending_reqs.pop_front();
        if (r.pick_live) begin
          live_idx.delete();
          for (int i = 0; i < LIVE_SLOTS; i++)
            if (blk_live[i]) live_idx.push_back(i);
          if (live_idx.size() > 0)
            r.fa = FADDR_W'(blk_start[live_idx[$urandom_range(live_idx.size() - 1)]]
                            + HEADER_BYTES);
        end
        in_valid <= 1'b1;
        action <= r.act;
        req_size <= r.sz;
        free_addr <= r.fa;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    resp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_resps.size() == 0) begin
        $display("%0t: unexpected result addr=%h status=%0d", $time, block_addr, status);
        errors++;
      end else begin
        e = awaited_resps.pop_front();
        n_checked++;
        if (block_addr !== e.addr) begin
          $display("%0t: block_addr expected %h actual %h", $time, e.addr, block_addr);
          errors++;
        end
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
        case (e.st)
          ST_OK:      n_ok++;
          ST_NOFIT:   n_nofit++;
          ST_BADFREE: n_bad++;
          default:    n_full++;
        endcase
      end
    end
    // one long hold-off while requests keep coming
    if (!hold_done && n_sent >= 250 && pending_reqs.size() > 20) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet() && $urandom_range(99) < 28;
    end
  end

  // Run limit
  always @(posedge clk) begin
    if (cycle_no > LIMIT_CYCLES) begin
      $display("timeout at cycle %0d", cycle_no);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_REGION) begin
      region_sz = longint'(val);
      if (region_sz < 4096) region_sz = 4096;
      if (region_sz > TOP_BYTES) region_sz = TOP_BYTES;
      clear_tables();
    end else begin
      policy = val[1:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_req(logic act, logic [SIZE_W-1:0] sz, logic [FADDR_W-1:0] fa,
                         bit live);
    req_t r;
    r.act = act;
    r.sz = sz;
    r.fa = fa;
    r.pick_live = live;
    pending_reqs.push_back(r);
  endtask

  // Sender pause: wait for all results, then for the block to settle
  task automatic settle();
    wait (pending_reqs.size() == 0 && !in_valid && awaited_resps.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_reqs(int n);
    int k;
    logic [SIZE_W-1:0] sz;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 52) begin
        k = $urandom_range(99);
        if (k < 70) sz = SIZE_W'($urandom_range(256, 1));
        else if (k < 82) sz = SIZE_W'($urandom_range(2048, 257));
        else if (k < 90) sz = SIZE_W'($urandom_range(region_sz / 4, 1));
        else if (k < 95) sz = '0;
        else sz = SIZE_W'($urandom);
        add_req(ACT_ALLOC, sz, FADDR_W'($urandom), 1'b0);
      end else if (k < 92) begin
        add_req(ACT_FREE, SIZE_W'($urandom), FADDR_W'($urandom), 1'b1);
      end else begin
        add_req(ACT_FREE, SIZE_W'($urandom), FADDR_W'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    region_sz = REGION_RESET;
    policy = POL_FIRST;
    clear_tables();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, first fit, region of 64 KiB
    add_req(ACT_ALLOC, 21'd1, '0, 1'b0);
    add_req(ACT_ALLOC, 21'd4, '0, 1'b0);
    add_req(ACT_ALLOC, 21'd5, '0, 1'b0);
    add_req(ACT_ALLOC, 21'd0, '0, 1'b0);
    add_req(ACT_ALLOC, 21'h1FFFFF, '0, 1'b0);
    add_req(ACT_FREE, 21'h1FFFFF, 20'd20, 1'b0);
    add_req(ACT_FREE, '0, 20'd8, 1'b0);
    add_req(ACT_FREE, '0, 20'd32, 1'b0);
    add_req(ACT_FREE, '0, 20'd32, 1'b0);
    add_req(ACT_ALLOC, 21'd65528, '0, 1'b0);
    add_req(ACT_ALLOC, 21'd1, '0, 1'b0);
    add_req(ACT_FREE, '0, 20'hFFFFF, 1'b0);
    add_req(ACT_FREE, '0, 20'd8, 1'b0);
    add_req(ACT_FREE, '0, 20'd0, 1'b0);
    // fill the live table, then one more
    for (int i = 0; i < LIVE_SLOTS + 1; i++) add_req(ACT_ALLOC, 21'd16, '0, 1'b0);
    settle();
    // every other block back: many separate free segments
    for (int i = 0; i < LIVE_SLOTS; i += 2) add_req(ACT_FREE, '0, 20'(i * 24 + 8), 1'b0);
    settle();

    // Random phases over region sizes and policies
    write_reg(REG_REGION, '0);
    write_reg(REG_POLICY, CFG_W'(POL_BEST));
    random_reqs(100);
    settle();
    write_reg(REG_POLICY, CFG_W'(POL_WORST));
    random_reqs(100);
    settle();
    write_reg(REG_REGION, 21'h1FFFFF);
    write_reg(REG_POLICY, CFG_W'(3));
    random_reqs(100);
    settle();
    write_reg(REG_REGION, 21'd1048576);
    write_reg(REG_POLICY, CFG_W'(POL_FIRST));
    random_reqs(100);
    settle();
    write_reg(REG_REGION, CFG_W'($urandom_range(20000, 4097)));
    write_reg(REG_POLICY, CFG_W'(POL_BEST));
    random_reqs(100);
    settle();
    write_reg(REG_REGION, 21'd4096);
    write_reg(REG_POLICY, CFG_W'(POL_WORST));
    random_reqs(100);
    settle();

    $display("covered %0d requests: %0d ok, %0d no fit, %0d bad free, %0d table full",
             n_sent, n_ok, n_nofit, n_bad, n_full);
    $display("region sizes from 4 KiB to 1 MiB under all four policy codes");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
